[rtl/btb2l_pkg.sv]
// Shared types and constants for the two-level branch predictor with target buffer.
package btb2l_pkg;

  // Sizes of the target buffer and the counter store
  localparam int EntryIdxW = 5;
  localparam int EntryDepth = 1 << EntryIdxW;
  localparam int MaxIdxBits = 5;
  localparam int TagW = 30;
  localparam int AddrW = 32;
  localparam int HistW = 8;
  localparam int CtrLaneW = 3;
  localparam int CtrLanes = 1 << CtrLaneW;
  localparam int CtrRowW = EntryIdxW + HistW - CtrLaneW;
  localparam int CtrWordW = 2 * CtrLanes;

  // Stream payload widths
  localparam int InDataW = 104;
  localparam int OutDataW = 104;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_BTB_INDEX_BITS = 3'd0,
    CFG_HISTORY_LENGTH = 3'd1,
    CFG_TAG_WIDTH      = 3'd2,
    CFG_INIT_COUNTER   = 3'd3,
    CFG_GLOBAL_HISTORY = 3'd4,
    CFG_GLOBAL_TABLE   = 3'd5,
    CFG_SHARE_MODE     = 3'd6
  } cfg_index_t;

  // Share modes
  localparam logic [1:0] SHARE_NONE = 2'd0;
  localparam logic [1:0] SHARE_LSB  = 2'd1;
  localparam logic [1:0] SHARE_MID  = 2'd2;

  // Item kinds
  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_UPDATE  = 1'b1;

  // One target buffer entry
  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [AddrW-1:0] target;
    logic [HistW-1:0] hist;
  } entry_t;

  // Access request to the entry memory
  typedef struct packed {
    logic                 re;
    logic                 we;
    logic [EntryIdxW-1:0] addr;
  } btb_req_t;

  // Access request to the counter memory
  typedef struct packed {
    logic               re;
    logic               we;
    logic [CtrRowW-1:0] addr;
  } ctr_req_t;

endpackage

[rtl/btb2l_entry_ram.sv]
// Target buffer memory: tag, target and local history per entry.
module btb2l_entry_ram (
  input  logic                clk,
  input  btb2l_pkg::btb_req_t req,
  input  btb2l_pkg::entry_t   wdata,
  output btb2l_pkg::entry_t   rdata
);

  btb2l_pkg::entry_t mem [btb2l_pkg::EntryDepth];

  // Synchronous write and registered read; the read data holds between reads.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

[rtl/btb2l_ctr_ram.sv]
// Counter memory: rows of eight 2-bit saturating counters.
module btb2l_ctr_ram (
  input  logic                                clk,
  input  btb2l_pkg::ctr_req_t                 req,
  input  logic [btb2l_pkg::CtrWordW-1:0]      wdata,
  output logic [btb2l_pkg::CtrWordW-1:0]      rdata
);

  logic [btb2l_pkg::CtrWordW-1:0] mem [1 << btb2l_pkg::CtrRowW];

  // Synchronous write and registered read; the read data holds between reads.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

[rtl/btb_two_level_branch_predictor.sv]
// Top level: direct-mapped target buffer with two-level adaptive direction prediction.
//
//   port group        dir  beat contents
//   s_t* (input)      in   kind in tuser; pc, target_pc, taken, predicted_dest in tdata
//   m_t* (output)     out  predict_taken, next_address, flush, branch_count, flush_count
//   cfg_* (config)    in   write enable, register index, register value
//
// Each item goes through accept with the entry memory read, the counter memory
// read, then the result and the write-back of both memories.
// A result that is not taken holds the item in its last cycle; one result waits
// in the output register while the next item is read.
// Reset and every known-register configuration write start a clearing pass over all
// 1024 counter rows (the first 32 also clear the entries); no item is accepted then.
module btb_two_level_branch_predictor (
  input  logic         clk,
  input  logic         rst,
  // Input beat
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: pc[31:0], target_pc[63:32], taken[64], predicted_dest[96:65], zero fill
  input  logic [btb2l_pkg::InDataW-1:0] s_tdata,
  // tuser: kind[0]
  input  logic         s_tuser,
  // Output beat
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: predict_taken[0], next_address[32:1], flush[33], branch_count[65:34],
  //        flush_count[97:66], zero fill
  output logic [btb2l_pkg::OutDataW-1:0] m_tdata,
  // Configuration writes
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [4:0]   cfg_data
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_CTR   = 4'b1000
  } state_t;

  state_t state;

  // Configuration registers
  logic [2:0] btb_index_bits;
  logic [3:0] history_length;
  logic [4:0] tag_width;
  logic [1:0] initial_counter_state;
  logic       global_history;
  logic       global_table;
  logic [1:0] share_mode;
  logic       cfg_hit;

  // Effective settings
  logic [2:0] ib_eff;
  logic [3:0] hl_eff;
  logic [4:0] tb_limit;
  logic [4:0] tb_eff;
  logic [btb2l_pkg::EntryIdxW-1:0] emask;
  logic [btb2l_pkg::HistW-1:0]     hmask;
  logic [btb2l_pkg::TagW-1:0]      tmask;

  // Item registers
  logic                              kind_q;
  logic [btb2l_pkg::AddrW-1:0]       pc_q;
  logic [btb2l_pkg::AddrW-1:0]       tgt_q;
  logic                              tk_q;
  logic [btb2l_pkg::AddrW-1:0]       pred_q;
  logic [btb2l_pkg::EntryIdxW-1:0]   e_q;
  logic [btb2l_pkg::CtrRowW-1:0]     row_q;
  logic [btb2l_pkg::CtrLaneW-1:0]    lane_q;
  logic [btb2l_pkg::HistW-1:0]       h_q;

  // Control registers
  logic [btb2l_pkg::CtrRowW-1:0]     clr_row;
  logic [btb2l_pkg::HistW-1:0]       shared_hist;
  logic [31:0]                       branches_seen;
  logic [31:0]                       flushes_seen;

  // Datapath signals
  logic                              accept;
  logic                              ctr_fire;
  logic [btb2l_pkg::AddrW-1:0]       s_pc;
  logic [btb2l_pkg::EntryIdxW-1:0]   e_in;
  logic [btb2l_pkg::HistW-1:0]       h_cur;
  logic [btb2l_pkg::HistW-1:0]       xor_val;
  logic [btb2l_pkg::HistW-1:0]       ci;
  logic [btb2l_pkg::EntryIdxW-1:0]   tbl;
  logic [btb2l_pkg::AddrW-1:0]       pc_shift;
  logic [btb2l_pkg::TagW-1:0]        tag_cur;
  logic [1:0]                        ctr_val;
  logic [1:0]                        ctr_new;
  logic [btb2l_pkg::HistW-1:0]       h_new;
  logic [btb2l_pkg::AddrW-1:0]       pc_plus4;
  logic                              hit;
  logic                              ptaken;
  logic                              flush;
  logic [31:0]                       branches_next;
  logic [31:0]                       flushes_next;
  logic [btb2l_pkg::CtrWordW-1:0]    ctr_word_new;

  // Memory ports
  btb2l_pkg::btb_req_t               btb_req;
  btb2l_pkg::entry_t                 btb_wdata;
  btb2l_pkg::entry_t                 btb_rdata;
  btb2l_pkg::ctr_req_t               ctr_req;
  logic [btb2l_pkg::CtrWordW-1:0]    ctr_wdata;
  logic [btb2l_pkg::CtrWordW-1:0]    ctr_rdata;

  // A write to a known register reinitializes all state.
  always_comb begin
    case (btb2l_pkg::cfg_index_t'(cfg_index))
      btb2l_pkg::CFG_BTB_INDEX_BITS,
      btb2l_pkg::CFG_HISTORY_LENGTH,
      btb2l_pkg::CFG_TAG_WIDTH,
      btb2l_pkg::CFG_INIT_COUNTER,
      btb2l_pkg::CFG_GLOBAL_HISTORY,
      btb2l_pkg::CFG_GLOBAL_TABLE,
      btb2l_pkg::CFG_SHARE_MODE: cfg_hit = cfg_we;
      default:                   cfg_hit = 1'b0;
    endcase
  end

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      btb_index_bits        <= 3'd0;
      history_length        <= 4'd1;
      tag_width             <= 5'd0;
      initial_counter_state <= 2'd1;
      global_history        <= 1'b0;
      global_table          <= 1'b0;
      share_mode            <= btb2l_pkg::SHARE_NONE;
    end else if (cfg_we) begin
      case (btb2l_pkg::cfg_index_t'(cfg_index))
        btb2l_pkg::CFG_BTB_INDEX_BITS: btb_index_bits        <= cfg_data[2:0];
        btb2l_pkg::CFG_HISTORY_LENGTH: history_length        <= cfg_data[3:0];
        btb2l_pkg::CFG_TAG_WIDTH:      tag_width             <= cfg_data;
        btb2l_pkg::CFG_INIT_COUNTER:   initial_counter_state <= cfg_data[1:0];
        btb2l_pkg::CFG_GLOBAL_HISTORY: global_history        <= cfg_data[0];
        btb2l_pkg::CFG_GLOBAL_TABLE:   global_table          <= cfg_data[0];
        btb2l_pkg::CFG_SHARE_MODE:     share_mode            <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Clamp the settings to the ranges the hardware supports.
  always_comb begin
    ib_eff = (btb_index_bits > 3'(btb2l_pkg::MaxIdxBits)) ?
             3'(btb2l_pkg::MaxIdxBits) : btb_index_bits;
    if (history_length == 4'd0) begin
      hl_eff = 4'd1;
    end else if (history_length > 4'(btb2l_pkg::HistW)) begin
      hl_eff = 4'(btb2l_pkg::HistW);
    end else begin
      hl_eff = history_length;
    end
    tb_limit = 5'(btb2l_pkg::TagW) - {2'b00, ib_eff};
    tb_eff   = (tag_width > tb_limit) ? tb_limit : tag_width;
    emask    = (btb2l_pkg::EntryIdxW)'((6'd1 << ib_eff) - 6'd1);
    hmask    = (btb2l_pkg::HistW)'((9'd1 << hl_eff) - 9'd1);
    tmask    = (btb2l_pkg::TagW'(1) << tb_eff) - btb2l_pkg::TagW'(1);
  end

  // Input side
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign s_pc     = s_tdata[31:0];
  assign e_in     = s_pc[6:2] & emask;

  // Counter index from the history in use and the selected pc bits.
  always_comb begin
    h_cur = global_history ? shared_hist : btb_rdata.hist;
    case (share_mode)
      btb2l_pkg::SHARE_LSB: xor_val = pc_q[9:2];
      btb2l_pkg::SHARE_MID: xor_val = pc_q[23:16];
      default:              xor_val = '0;
    endcase
    ci  = (h_cur ^ xor_val) & hmask;
    tbl = global_table ? '0 : e_q;
  end

  // Result and write-back values in the last cycle of an item.
  always_comb begin
    pc_shift = (pc_q >> 2) >> ib_eff;
    tag_cur  = pc_shift[btb2l_pkg::TagW-1:0] & tmask;
    ctr_val  = ctr_rdata[lane_q*2 +: 2];
    if (tk_q) begin
      ctr_new = (ctr_val == 2'd3) ? ctr_val : ctr_val + 2'd1;
    end else begin
      ctr_new = (ctr_val == 2'd0) ? ctr_val : ctr_val - 2'd1;
    end
    h_new    = {h_q[btb2l_pkg::HistW-2:0], tk_q} & hmask;
    pc_plus4 = pc_q + 32'd4;
    hit      = (btb_rdata.tag == tag_cur);
    ptaken   = (kind_q == btb2l_pkg::KIND_PREDICT) && hit && ctr_val[1];
    flush    = (kind_q == btb2l_pkg::KIND_UPDATE) &&
               ((tk_q && (tgt_q != pred_q)) || (!tk_q && (pred_q != pc_plus4)));
    branches_next = branches_seen + {31'd0, kind_q == btb2l_pkg::KIND_PREDICT};
    flushes_next  = flushes_seen + {31'd0, flush};
    ctr_word_new = ctr_rdata;
    ctr_word_new[lane_q*2 +: 2] = ctr_new;
  end

  assign ctr_fire = (state == ST_CTR) && (!m_tvalid || m_tready);

  // Memory requests: clearing pass, item reads and the update write-back.
  always_comb begin
    btb_req.re   = accept;
    btb_req.we   = ((state == ST_CLEAR) && (clr_row[btb2l_pkg::CtrRowW-1:btb2l_pkg::EntryIdxW]
                    == '0)) || (ctr_fire && (kind_q == btb2l_pkg::KIND_UPDATE));
    if (state == ST_CLEAR) begin
      btb_req.addr = clr_row[btb2l_pkg::EntryIdxW-1:0];
    end else if (accept) begin
      btb_req.addr = e_in;
    end else begin
      btb_req.addr = e_q;
    end
    if (state == ST_CLEAR) begin
      btb_wdata = '0;
    end else begin
      btb_wdata.tag    = tag_cur;
      btb_wdata.target = tgt_q;
      btb_wdata.hist   = global_history ? btb_rdata.hist : h_new;
    end

    ctr_req.re = (state == ST_LOOK);
    ctr_req.we = (state == ST_CLEAR) || (ctr_fire && (kind_q == btb2l_pkg::KIND_UPDATE));
    if (state == ST_CLEAR) begin
      ctr_req.addr = clr_row;
      ctr_wdata    = {btb2l_pkg::CtrLanes{initial_counter_state}};
    end else begin
      ctr_req.addr = (state == ST_LOOK) ?
                     {tbl, ci[btb2l_pkg::HistW-1:btb2l_pkg::CtrLaneW]} : row_q;
      ctr_wdata    = ctr_word_new;
    end
  end

  // Sequencer, counters and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_row       <= '0;
      m_tvalid      <= 1'b0;
      shared_hist   <= '0;
      branches_seen <= '0;
      flushes_seen  <= '0;
    end else begin
      // A new result loads the output register; a taken beat empties it.
      if (ctr_fire && !cfg_hit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_hit) begin
        state         <= ST_CLEAR;
        clr_row       <= '0;
        shared_hist   <= '0;
        branches_seen <= '0;
        flushes_seen  <= '0;
      end else begin
        case (state)
          ST_CLEAR: begin
            clr_row <= clr_row + 1'b1;
            if (clr_row == '1) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (s_tvalid) begin
              state <= ST_LOOK;
            end
          end
          ST_LOOK: begin
            state <= ST_CTR;
          end
          ST_CTR: begin
            if (ctr_fire) begin
              state         <= ST_IDLE;
              branches_seen <= branches_next;
              flushes_seen  <= flushes_next;
              if ((kind_q == btb2l_pkg::KIND_UPDATE) && global_history) begin
                shared_hist <= h_new;
              end
            end
          end
          default: state <= ST_CLEAR;
        endcase
      end
    end
  end

  // Item payload and the output beat.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= s_tuser;
      pc_q   <= s_pc;
      tgt_q  <= s_tdata[63:32];
      tk_q   <= s_tdata[64];
      pred_q <= s_tdata[96:65];
      e_q    <= e_in;
    end
    if (state == ST_LOOK) begin
      row_q  <= {tbl, ci[btb2l_pkg::HistW-1:btb2l_pkg::CtrLaneW]};
      lane_q <= ci[btb2l_pkg::CtrLaneW-1:0];
      h_q    <= h_cur;
    end
    if (ctr_fire) begin
      m_tdata <= {6'd0, flushes_next, branches_next, flush,
                  ptaken ? btb_rdata.target :
                  ((kind_q == btb2l_pkg::KIND_PREDICT) ? pc_plus4 : 32'd0),
                  ptaken};
    end
  end

  btb2l_entry_ram u_entry_ram (
    .clk   (clk),
    .req   (btb_req),
    .wdata (btb_wdata),
    .rdata (btb_rdata)
  );

  btb2l_ctr_ram u_ctr_ram (
    .clk   (clk),
    .req   (ctr_req),
    .wdata (ctr_wdata),
    .rdata (ctr_rdata)
  );

endmodule

[tb/tb_btb_two_level_branch_predictor.sv]
// Self-checking testbench for the two-level branch predictor with target buffer.
`timescale 1ns / 100ps

module tb_btb_two_level_branch_predictor;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned ItemsPerPhase = 180;
  localparam int unsigned NumPhases = 10;
  localparam int unsigned LongHold = 400;
  // Share mode with no name in the package; the block treats it as no XOR.
  localparam logic [1:0] SHARE_UNUSED = 2'd3;

  // Result beat, lowest field last
  typedef struct packed {
    logic [31:0] flush_count;
    logic [31:0] branch_count;
    logic        flush;
    logic [31:0] next_address;
    logic        predict_taken;
  } bp_result_t;

  // One directed row; typed rows carry their result written out by hand.
  typedef struct {
    logic        kind;
    logic [31:0] pc;
    logic [31:0] target_pc;
    logic        taken;
    logic [31:0] predicted_dest;
    bit          typed;
    bp_result_t  res;
  } dir_row_t;

  // Settings of all seven registers for one phase
  typedef struct {
    logic [4:0] idx_bits;
    logic [4:0] hist_len;
    logic [4:0] tag_len;
    logic [4:0] init_ctr;
    logic [4:0] ghist;
    logic [4:0] gtable;
    logic [4:0] share;
  } phase_cfg_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         s_tuser = btb2l_pkg::KIND_PREDICT;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = btb2l_pkg::CFG_BTB_INDEX_BITS;
  logic [4:0]   cfg_data = '0;

  btb_two_level_branch_predictor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor copy of the configuration
  logic [2:0] cf_idx_bits;
  logic [3:0] cf_hist_len;
  logic [4:0] cf_tag_len;
  logic [1:0] cf_init_ctr;
  logic       cf_ghist;
  logic       cf_gtable;
  logic [1:0] cf_share;

  // Predictor copy of the buffer, histories, counters and statistics
  logic [29:0] bp_tag [32];
  logic [31:0] bp_target [32];
  logic [7:0]  bp_hist [32];
  logic [7:0]  bp_ghist;
  logic [1:0]  bp_ctr_entry [8192];
  logic [1:0]  bp_ctr_shared [256];
  logic [31:0] bp_branches;
  logic [31:0] bp_flushes;

  bp_result_t  pending_results[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned n_predicts = 0;
  int unsigned n_updates = 0;
  int unsigned n_taken = 0;
  int unsigned n_flushes = 0;
  int unsigned cycles = 0;
  int unsigned src_burst = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Clear all predictor state to the values after a register write.
  function automatic void clear_state();
    for (int i = 0; i < 32; i++) begin
      bp_tag[i] = '0;
      bp_target[i] = '0;
      bp_hist[i] = '0;
    end
    for (int i = 0; i < 8192; i++) bp_ctr_entry[i] = cf_init_ctr;
    for (int i = 0; i < 256; i++) bp_ctr_shared[i] = cf_init_ctr;
    bp_ghist = '0;
    bp_branches = '0;
    bp_flushes = '0;
  endfunction

  function automatic void apply_reg(btb2l_pkg::cfg_index_t idx, logic [4:0] val);
    case (idx)
      btb2l_pkg::CFG_BTB_INDEX_BITS: cf_idx_bits = val[2:0];
      btb2l_pkg::CFG_HISTORY_LENGTH: cf_hist_len = val[3:0];
      btb2l_pkg::CFG_TAG_WIDTH:      cf_tag_len = val;
      btb2l_pkg::CFG_INIT_COUNTER:   cf_init_ctr = val[1:0];
      btb2l_pkg::CFG_GLOBAL_HISTORY: cf_ghist = val[0];
      btb2l_pkg::CFG_GLOBAL_TABLE:   cf_gtable = val[0];
      btb2l_pkg::CFG_SHARE_MODE:     cf_share = val[1:0];
      default: ;
    endcase
    clear_state();
  endfunction

  // Index bits saturate at five; history length is kept within one to eight.
  function automatic int unsigned eff_idx_bits();
    return (cf_idx_bits > 3'd5) ? 5 : int'(cf_idx_bits);
  endfunction

  function automatic int unsigned eff_hist_len();
    if (cf_hist_len == 4'd0) return 1;
    if (cf_hist_len > 4'd8) return 8;
    return int'(cf_hist_len);
  endfunction

  // Counter address: within the shared table, or within the entry's own table.
  function automatic int unsigned ctr_addr(int unsigned e, logic [31:0] pc);
    logic [31:0] h;
    logic [31:0] ci;
    h = cf_ghist ? {24'd0, bp_ghist} : {24'd0, bp_hist[e]};
    case (cf_share)
      btb2l_pkg::SHARE_LSB: ci = h ^ (pc >> 2);
      btb2l_pkg::SHARE_MID: ci = h ^ (pc >> 16);
      default:              ci = h;
    endcase
    ci &= (32'd1 << eff_hist_len()) - 32'd1;
    return cf_gtable ? int'(ci) : e * 256 + int'(ci);
  endfunction

  // Apply one item to the predictor and return the result it must produce.
  function automatic bp_result_t predict_item(logic kind, logic [31:0] pc, logic [31:0] tgt,
                                              logic tk, logic [31:0] pred);
    bp_result_t  r;
    int unsigned ib;
    int unsigned tb;
    int unsigned e;
    int unsigned ca;
    logic [29:0] tag;
    logic [1:0]  c;
    logic [7:0]  h;
    ib = eff_idx_bits();
    tb = (int'(cf_tag_len) > 30 - ib) ? 30 - ib : int'(cf_tag_len);
    e = int'((pc >> 2) & ((32'd1 << ib) - 32'd1));
    tag = 30'((pc >> (2 + ib)) & ((32'd1 << tb) - 32'd1));
    ca = ctr_addr(e, pc);
    c = cf_gtable ? bp_ctr_shared[ca] : bp_ctr_entry[ca];
    r = '0;
    if (kind == btb2l_pkg::KIND_PREDICT) begin
      bp_branches = bp_branches + 32'd1;
      r.next_address = pc + 32'd4;
      if (bp_tag[e] == tag && c >= 2'd2) begin
        r.predict_taken = 1'b1;
        r.next_address = bp_target[e];
      end
    end else begin
      if ((tk && tgt != pred) || (!tk && pred != pc + 32'd4)) begin
        r.flush = 1'b1;
        bp_flushes = bp_flushes + 32'd1;
      end
      bp_target[e] = tgt;
      bp_tag[e] = tag;
      if (tk) begin
        if (c != 2'd3) c = c + 2'd1;
      end else if (c != 2'd0) begin
        c = c - 2'd1;
      end
      if (cf_gtable) bp_ctr_shared[ca] = c;
      else bp_ctr_entry[ca] = c;
      h = cf_ghist ? bp_ghist : bp_hist[e];
      h = ((h << 1) | {7'd0, tk}) & 8'((32'd1 << eff_hist_len()) - 32'd1);
      if (cf_ghist) bp_ghist = h;
      else bp_hist[e] = h;
    end
    r.branch_count = bp_branches;
    r.flush_count = bp_flushes;
    return r;
  endfunction

  // Source gap: runs of back-to-back beats alternate with random gaps.
  function automatic int unsigned draw_src_gap();
    if (src_burst > 0) begin
      src_burst--;
      return 0;
    end
    if ($urandom_range(0, 99) < 8) begin
      src_burst = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Offer one input beat and wait until it is taken.
  task automatic send_item(input logic kind, input logic [31:0] pc, input logic [31:0] tgt,
                           input logic tk, input logic [31:0] pred, input bit typed,
                           input bp_result_t typed_res, output bp_result_t res);
    int unsigned gap;
    gap = draw_src_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {7'd0, pred, tk, tgt, pc};
    res = predict_item(kind, pc, tgt, tk, pred);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
    if (kind == btb2l_pkg::KIND_PREDICT) n_predicts++;
    else n_updates++;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // Write all seven registers once the block has drained.
  task automatic write_all(phase_cfg_t p);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    for (int i = 0; i < 7; i++) begin
      btb2l_pkg::cfg_index_t idx;
      logic [4:0] val;
      idx = btb2l_pkg::cfg_index_t'(i);
      case (idx)
        btb2l_pkg::CFG_BTB_INDEX_BITS: val = p.idx_bits;
        btb2l_pkg::CFG_HISTORY_LENGTH: val = p.hist_len;
        btb2l_pkg::CFG_TAG_WIDTH:      val = p.tag_len;
        btb2l_pkg::CFG_INIT_COUNTER:   val = p.init_ctr;
        btb2l_pkg::CFG_GLOBAL_HISTORY: val = p.ghist;
        btb2l_pkg::CFG_GLOBAL_TABLE:   val = p.gtable;
        default:                       val = p.share;
      endcase
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      apply_reg(idx, val);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] g);
    if (e !== g) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, g);
    end
  endtask

  // Result side: random stalls, two long hold-offs, and the check of every beat.
  initial begin : result_sink
    int unsigned hold;
    int unsigned burst;
    bp_result_t  want;
    bp_result_t  got;
    burst = 0;
    while (rst) @(posedge clk);
    forever begin
      if (results_seen == 300 || results_seen == 1100) begin
        hold = LongHold;
      end else if (burst > 0) begin
        burst--;
        hold = 0;
      end else if ($urandom_range(0, 99) < 8) begin
        burst = $urandom_range(20, 60);
        hold = 0;
      end else begin
        hold = $urandom_range(0, 18);
      end
      if (hold != 0) begin
        m_tready <= 1'b0;
        for (int i = 0; i < hold; i++) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      results_seen++;
      got = m_tdata[97:0];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (want.predict_taken) n_taken++;
        if (want.flush) n_flushes++;
        check_field("predict_taken", 32'(want.predict_taken), 32'(got.predict_taken));
        check_field("next_address", want.next_address, got.next_address);
        check_field("flush", 32'(want.flush), 32'(got.flush));
        check_field("branch_count", want.branch_count, got.branch_count);
        check_field("flush_count", want.flush_count, got.flush_count);
      end
    end
  end

  // Directed rows under the reset settings: one entry, tag of zero width,
  // history of one bit, counters weakly not taken.
  dir_row_t dir_rows[14] = '{
    '{btb2l_pkg::KIND_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 32'h0, 1'b1,
      '{32'd0, 32'd1, 1'b0, 32'h0000_0004, 1'b0}},
    '{btb2l_pkg::KIND_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0, 1'b1,
      '{32'd0, 32'd2, 1'b0, 32'h0000_0000, 1'b0}},
    '{btb2l_pkg::KIND_UPDATE, 32'h0000_0000, 32'h0000_1000, 1'b1, 32'h0000_1000, 1'b1,
      '{32'd0, 32'd2, 1'b0, 32'h0, 1'b0}},
    '{btb2l_pkg::KIND_UPDATE, 32'h0000_0000, 32'h0000_1000, 1'b0, 32'h0000_0004, 1'b1,
      '{32'd0, 32'd2, 1'b0, 32'h0, 1'b0}},
    '{btb2l_pkg::KIND_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1,
      '{32'd1, 32'd2, 1'b1, 32'h0, 1'b0}},
    '{btb2l_pkg::KIND_UPDATE, 32'h0000_0000, 32'hA5A5_A5A4, 1'b0, 32'h0000_0000, 1'b1,
      '{32'd2, 32'd2, 1'b1, 32'h0, 1'b0}},
    '{btb2l_pkg::KIND_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 32'h0, 1'b0, '0},
    '{btb2l_pkg::KIND_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, '0},
    '{btb2l_pkg::KIND_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0, '0},
    '{btb2l_pkg::KIND_UPDATE, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h0000_0001, 1'b0, '0},
    '{btb2l_pkg::KIND_PREDICT, 32'h8000_0000, 32'h0, 1'b0, 32'h0, 1'b0, '0},
    '{btb2l_pkg::KIND_UPDATE, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0, 32'h1234_567C, 1'b0, '0},
    '{btb2l_pkg::KIND_PREDICT, 32'h1234_5678, 32'h0, 1'b0, 32'h0, 1'b0, '0},
    '{btb2l_pkg::KIND_UPDATE, 32'hFFFF_FFFC, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000, 1'b0, '0}
  };

  // Phase settings: extremes, the out-of-range values the block clamps,
  // and the shared and per-entry combinations; the last two are drawn at random.
  phase_cfg_t phases[NumPhases - 1] = '{
    '{5'd2, 5'd4, 5'd8,  5'd1, 5'd1, 5'd1, 5'(btb2l_pkg::SHARE_LSB)},
    '{5'd5, 5'd8, 5'd30, 5'd3, 5'd0, 5'd0, 5'(btb2l_pkg::SHARE_MID)},
    '{5'd0, 5'd1, 5'd0,  5'd0, 5'd1, 5'd0, 5'(btb2l_pkg::SHARE_NONE)},
    '{5'd3, 5'd8, 5'd12, 5'd2, 5'd0, 5'd1, 5'(btb2l_pkg::SHARE_NONE)},
    '{5'd7, 5'd0, 5'd31, 5'd2, 5'd1, 5'd1, 5'(SHARE_UNUSED)},
    '{5'd4, 5'd15, 5'd31, 5'd0, 5'd0, 5'd0, 5'(btb2l_pkg::SHARE_LSB)},
    '{5'd5, 5'd6, 5'd20, 5'd1, 5'd1, 5'd0, 5'(btb2l_pkg::SHARE_MID)},
    '{5'd0, 5'd0, 5'd0,  5'd0, 5'd0, 5'd0, 5'(btb2l_pkg::SHARE_NONE)},
    '{5'd0, 5'd0, 5'd0,  5'd0, 5'd0, 5'd0, 5'(btb2l_pkg::SHARE_NONE)}
  };

  // Random items for one phase: mostly predict/update pairs over a small set
  // of branches, with the rest lone updates and unrelated items.
  task automatic run_random(int unsigned count);
    logic [31:0] pool_pc [8];
    logic [31:0] pool_tgt [8];
    int unsigned pool_bias [8];
    int unsigned pool_n;
    int unsigned sent;
    int unsigned s;
    int unsigned pick;
    logic        tk;
    logic [31:0] pred;
    bp_result_t  res;
    pool_n = $urandom_range(2, 8);
    for (int i = 0; i < 8; i++) begin
      pool_pc[i] = $urandom;
      pool_tgt[i] = $urandom;
      pool_bias[i] = $urandom_range(0, 100);
    end
    sent = 0;
    while (sent < count) begin
      s = $urandom_range(0, pool_n - 1);
      pick = $urandom_range(0, 99);
      tk = ($urandom_range(0, 99) < pool_bias[s]);
      if ($urandom_range(0, 19) == 0) pool_tgt[s] = $urandom;
      if (pick < 70) begin
        // Well-formed pair: the update reports back what was predicted.
        send_item(btb2l_pkg::KIND_PREDICT, pool_pc[s], $urandom, 1'($urandom_range(0, 1)),
                  $urandom, 1'b0, '0, res);
        pred = ($urandom_range(0, 9) == 0) ? 32'($urandom) : res.next_address;
        send_item(btb2l_pkg::KIND_UPDATE, pool_pc[s], pool_tgt[s], tk, pred, 1'b0, '0, res);
        sent += 2;
      end else if (pick < 85) begin
        case ($urandom_range(0, 2))
          0:       pred = pool_pc[s] + 32'd4;
          1:       pred = pool_tgt[s];
          default: pred = $urandom;
        endcase
        send_item(btb2l_pkg::KIND_UPDATE, pool_pc[s], pool_tgt[s], tk, pred, 1'b0, '0, res);
        sent++;
      end else begin
        send_item(1'($urandom_range(0, 1)), $urandom, $urandom, 1'($urandom_range(0, 1)),
                  $urandom, 1'b0, '0, res);
        sent++;
      end
    end
  endtask

  // Main sequence: reset, directed rows, then one random phase per setting.
  initial begin : stimulus
    bp_result_t res;
    phase_cfg_t p;
    cf_idx_bits = 3'd0;
    cf_hist_len = 4'd1;
    cf_tag_len = 5'd0;
    cf_init_ctr = 2'd1;
    cf_ghist = 1'b0;
    cf_gtable = 1'b0;
    cf_share = btb2l_pkg::SHARE_NONE;
    clear_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].kind, dir_rows[i].pc, dir_rows[i].target_pc, dir_rows[i].taken,
                dir_rows[i].predicted_dest, dir_rows[i].typed, dir_rows[i].res, res);
    end
    run_random(ItemsPerPhase);

    for (int ph = 0; ph < NumPhases - 1; ph++) begin
      p = phases[ph];
      if (ph >= NumPhases - 3) begin
        p.idx_bits = 5'($urandom_range(0, 7));
        p.hist_len = 5'($urandom_range(0, 15));
        p.tag_len = 5'($urandom_range(0, 31));
        p.init_ctr = 5'($urandom_range(0, 3));
        p.ghist = 5'($urandom_range(0, 1));
        p.gtable = 5'($urandom_range(0, 1));
        p.share = 5'($urandom_range(0, 3));
      end
      write_all(p);
      run_random(ItemsPerPhase);
    end

    // Drain, then allow a few cycles for any stray beat.
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d register settings with %0d predicts and %0d updates.",
             NumPhases, n_predicts, n_updates);
    $display("Saw %0d taken predictions and %0d flushes; %0d mismatches.",
             n_taken, n_flushes, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
